[hw/rtl/mme_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the min multiset event engine.
// No dependencies; every other file of the block but mme_if imports this package.
package mme_pkg;

    localparam int OP_W      = 2;
    localparam int VALUE_W   = 32;
    localparam int TAG_W     = 16;
    localparam int STATUS_W  = 2;

    // Raw op codes as they arrive on the event channel.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Command queue between the front and the back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    typedef enum logic [1:0] {
        KIND_INSERT,
        KIND_REMOVE,
        KIND_QUERY
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EVAL,
        BK_COMMIT
    } back_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
        logic [TAG_W-1:0]    tag;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[hw/rtl/mme_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the event input and the result output.
// Field widths follow the constants of mme_pkg.
interface mme_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] value;
    logic [15:0] tag;

    modport source (output valid, output op, output value, output tag, input ready);
    modport sink   (input valid, input op, input value, input tag, output ready);
endinterface

interface mme_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] tag_out;
    logic [31:0] min_value;
    logic        is_empty;
    logic [1:0]  status;

    modport source (output valid, output tag_out, output min_value, output is_empty,
                    output status, input ready);
    modport sink   (input valid, input tag_out, input min_value, input is_empty,
                    input status, output ready);
endinterface

[hw/rtl/min_multiset_event_engine.sv]
`timescale 1ns / 1ps
// Min multiset event engine: bounded sorted store with insert, remove and min query.
// An event passes the front slot register, the command queue, the back end's command
// register, its compare flag registers and the result register. The back end takes one
// command at a time through its compare and commit states and pops the next on commit.
// Reset clears occupancy, queue and result valid at once; cell contents are not cleared.
module min_multiset_event_engine #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    mme_evt_if.sink    evt,
    mme_res_if.source  res
);
    import mme_pkg::*;

    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head_cmd;
    q_status_t q_stat;

    mme_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .push     (push),
        .push_cmd (push_cmd),
        .q_stat   (q_stat)
    );

    mme_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    mme_back #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head_cmd (head_cmd),
        .pop      (pop),
        .res      (res)
    );

endmodule

[hw/rtl/mme_front.sv]
`timescale 1ns / 1ps
// Front end: accepts event items, decodes the op into a command kind and
// holds the command in one stage until the queue takes it. Uses mme_pkg, mme_if.
module mme_front (
    input  logic         clk,
    input  logic         rst_n,
    mme_evt_if.sink      evt,
    output logic         push,
    output mme_pkg::cmd_t push_cmd,
    input  mme_pkg::q_status_t q_stat
);
    import mme_pkg::*;

    logic  slot_valid_reg;
    logic  slot_valid_next;
    cmd_t  slot_cmd_reg;
    cmd_t  slot_cmd_next;
    kind_t kind_dec;
    logic  take;

    always_comb
    begin
        unique case (evt.op)
            OP_INSERT: kind_dec = KIND_INSERT;
            OP_REMOVE: kind_dec = KIND_REMOVE;
            // The unused code is handled like a query.
            default:   kind_dec = KIND_QUERY;
        endcase
    end

    assign push      = slot_valid_reg & ~q_stat.full;
    assign evt.ready = ~slot_valid_reg | ~q_stat.full;
    assign take      = evt.valid & evt.ready;
    assign push_cmd  = slot_cmd_reg;

    always_comb
    begin
        slot_valid_next = take | (slot_valid_reg & ~push);
        slot_cmd_next   = slot_cmd_reg;
        if (take)
        begin
            slot_cmd_next = '{kind: kind_dec, value: evt.value, tag: evt.tag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_cmd_reg <= slot_cmd_next;
    end

endmodule

[hw/rtl/mme_queue.sv]
`timescale 1ns / 1ps
// Short command queue that decouples the front end from the back end.
// Depth and pointer widths come from mme_pkg.
module mme_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mme_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output mme_pkg::cmd_t      head_cmd,
    output mme_pkg::q_status_t q_stat
);
    import mme_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    assign head_cmd     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/mme_back.sv]
`timescale 1ns / 1ps
// Back end: a row of sorted cells with per-cell compare flags, a small
// sequencer and the result register. Uses mme_pkg and mme_res_if.
module mme_back #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mme_pkg::q_status_t q_stat,
    input  mme_pkg::cmd_t      head_cmd,
    output logic               pop,
    mme_res_if.source          res
);
    import mme_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    // Cells hold values in ascending order; occ_reg is a thermometer of used cells.
    logic [VALUE_BITS-1:0] cell_reg  [CAPACITY];
    logic [VALUE_BITS-1:0] cell_next [CAPACITY];
    logic [VALUE_BITS-1:0] ins_cell  [CAPACITY];
    logic [VALUE_BITS-1:0] rem_cell  [CAPACITY];
    logic [CAPACITY-1:0]   occ_reg;
    logic [CAPACITY-1:0]   occ_next;

    cmd_t                  cmd_reg;
    logic [VALUE_BITS-1:0] v;

    logic [CAPACITY-1:0]   lt_reg;
    logic [CAPACITY-1:0]   eq_reg;
    logic [CAPACITY-1:0]   lt_next;
    logic [CAPACITY-1:0]   eq_next;
    logic [CAPACITY-1:0]   le;
    logic [CAPACITY-1:0]   le_below;
    logic [CAPACITY-1:0]   ge;
    logic [CAPACITY-1:0]   occ_above;
    logic [CAPACITY-1:0]   ins_occ;
    logic [CAPACITY-1:0]   rem_occ;
    logic                  found;
    logic                  full;
    logic                  commit_fire;

    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic [TAG_W-1:0]      res_tag_reg;
    logic [VALUE_W-1:0]    res_min_reg;
    logic                  res_empty_reg;
    status_t               res_status_reg;
    status_t               status_next;

    assign v = VALUE_BITS'(cmd_reg.value);

    // Compare stage: every cell compares its own value with the command value.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt_next[i] = occ_reg[i] & (cell_reg[i] < v);
            eq_next[i] = occ_reg[i] & (cell_reg[i] == v);
        end
    end

    assign le        = lt_reg | eq_reg;
    assign le_below  = {le[CAPACITY-2:0], 1'b1};
    assign ge        = occ_reg & ~lt_reg;
    assign occ_above = {1'b0, occ_reg[CAPACITY-1:1]};
    assign ins_occ   = {occ_reg[CAPACITY-2:0], 1'b1};
    assign rem_occ   = (ge & occ_above) | (~ge & occ_reg);
    assign found     = |eq_reg;
    assign full      = occ_reg[CAPACITY-1];

    // An insert shifts every cell above the insertion point up by one; a remove
    // shifts every cell at or above the first copy of the value down by one.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_bottom
            assign ins_cell[g] = le[g] ? cell_reg[g] : v;
            assign rem_cell[g] = ge[g] ? cell_reg[g+1] : cell_reg[g];
        end
        else if (g == CAPACITY - 1)
        begin : g_top
            assign ins_cell[g] = le[g] ? cell_reg[g] : (le_below[g] ? v : cell_reg[g-1]);
            assign rem_cell[g] = cell_reg[g];
        end
        else
        begin : g_mid
            assign ins_cell[g] = le[g] ? cell_reg[g] : (le_below[g] ? v : cell_reg[g-1]);
            assign rem_cell[g] = ge[g] ? cell_reg[g+1] : cell_reg[g];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pop         = 1'b0;
        commit_fire = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_EVAL;
                end
            end
            BK_EVAL:
            begin
                state_next = BK_COMMIT;
            end
            BK_COMMIT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    commit_fire = 1'b1;
                    if (!q_stat.empty)
                    begin
                        pop        = 1'b1;
                        state_next = BK_EVAL;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cell_next   = cell_reg;
        occ_next    = occ_reg;
        status_next = ST_OK;
        if (commit_fire)
        begin
            unique case (cmd_reg.kind)
                KIND_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cell_next = ins_cell;
                        occ_next  = ins_occ;
                    end
                end
                KIND_REMOVE:
                begin
                    if (!found)
                    begin
                        status_next = ST_ABSENT;
                    end
                    else
                    begin
                        cell_next = rem_cell;
                        occ_next  = rem_occ;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    assign res_valid_next = commit_fire | (res_valid_reg & ~res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            occ_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        if (pop)
        begin
            cmd_reg <= head_cmd;
        end
        if (state_reg == BK_EVAL)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
        if (commit_fire)
        begin
            res_tag_reg    <= cmd_reg.tag;
            res_min_reg    <= occ_next[0] ? VALUE_W'(cell_next[0]) : '0;
            res_empty_reg  <= ~occ_next[0];
            res_status_reg <= status_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.tag_out   = res_tag_reg;
    assign res.min_value = res_min_reg;
    assign res.is_empty  = res_empty_reg;
    assign res.status    = res_status_reg;

endmodule

[hw/rtl/mme_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the min multiset event engine, bound to the top level.
// Uses mme_pkg for the status codes.
module mme_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        evt_valid,
    input logic        evt_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] res_tag_out,
    input logic [31:0] res_min_value,
    input logic        res_is_empty,
    input logic [1:0]  res_status
);
    import mme_pkg::*;

    // Items accepted whose result has not been taken yet.
    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       evt_take;
    logic       res_take;

    assign evt_take     = evt_valid & evt_ready;
    assign res_take     = res_valid & res_ready;
    assign pending_next = pending_reg + 4'(evt_take) - 4'(res_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid
            && $stable({res_tag_out, res_min_value, res_is_empty, res_status}))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_is_empty |-> res_min_value == 32'd0)
        else $error("empty store reported a nonzero minimum");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_FULL |-> !res_is_empty)
        else $error("dropped insert reported an empty store");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 4'd0)
        else $error("result shown with no item outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd5)
        else $error("more items in flight than the pipeline holds");

endmodule

bind min_multiset_event_engine mme_checker u_mme_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .evt_valid     (evt.valid),
    .evt_ready     (evt.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_tag_out   (res.tag_out),
    .res_min_value (res.min_value),
    .res_is_empty  (res.is_empty),
    .res_status    (res.status)
);

[test/tb_min_multiset_event_engine.sv]
`timescale 1ns / 1ps
// Self-checking testbench for min_multiset_event_engine: it drives insert, remove and
// query events and checks every result against an internal sorted-store model.
// Depends on mme_pkg, the mme_evt_if / mme_res_if interfaces and the engine itself.
module tb_min_multiset_event_engine;
    import mme_pkg::*;

    localparam int STORE_CAP = 64;
    localparam int STALL_PCT = 27;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TARGET_ITEMS = 1050;
    localparam int TAIL_CYCLES = 20;
    // The op field has room for one code that the block treats as a query.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [TAG_W-1:0]   tag;
    } event_item_t;

    typedef struct {
        logic [TAG_W-1:0]   tag_out;
        logic [VALUE_W-1:0] min_value;
        logic               is_empty;
        status_t            status;
    } engine_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mme_evt_if evt_ch();
    mme_res_if res_ch();

    min_multiset_event_engine #(
        .CAPACITY   (STORE_CAP),
        .VALUE_BITS (VALUE_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch)
    );

    event_item_t        pending_events[$];
    engine_result_t     awaited_results[$];
    logic [VALUE_W-1:0] held_values[$];

    logic evt_fire = 1'b0;
    logic no_stall = 1'b0;
    int   mismatch_count = 0;
    int   total_pushed = 0;
    int   quiet_cycles = 0;

    always #4 clk = ~clk;

    initial
    begin
        evt_ch.valid = 1'b0;
        evt_ch.op    = '0;
        evt_ch.value = '0;
        evt_ch.tag   = '0;
        res_ch.ready = 1'b0;
    end

    // Applies one event to the model store and returns the result the block must give.
    function automatic engine_result_t apply_event(event_item_t ev);
        engine_result_t r;
        int pos;
        r.status = ST_OK;
        pos = 0;
        if (ev.op == OP_INSERT)
        begin
            if (held_values.size() >= STORE_CAP)
                r.status = ST_FULL;
            else
            begin
                while (pos < held_values.size() && held_values[pos] <= ev.value)
                    pos++;
                held_values.insert(pos, ev.value);
            end
        end
        else if (ev.op == OP_REMOVE)
        begin
            while (pos < held_values.size() && held_values[pos] < ev.value)
                pos++;
            if (pos >= held_values.size() || held_values[pos] != ev.value)
                r.status = ST_ABSENT;
            else
                held_values.delete(pos);
        end
        r.tag_out = ev.tag;
        if (held_values.size() == 0)
        begin
            r.min_value = '0;
            r.is_empty  = 1'b1;
        end
        else
        begin
            r.min_value = held_values[0];
            r.is_empty  = 1'b0;
        end
        return r;
    endfunction

    // Driver: a new item goes out only once the previous one was taken.
    always @(negedge clk)
    begin : drive_events
        event_item_t item;
        if (rst_n && (!evt_ch.valid || evt_fire))
        begin
            if (pending_events.size() > 0 && (no_stall || $urandom_range(0, 99) >= STALL_PCT))
            begin
                item = pending_events.pop_front();
                evt_ch.valid <= 1'b1;
                evt_ch.op    <= item.op;
                evt_ch.value <= item.value;
                evt_ch.tag   <= item.tag;
            end
            else
                evt_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            res_ch.ready <= no_stall || ($urandom_range(0, 99) >= STALL_PCT);
    end

    always @(posedge clk)
    begin : predict_events
        event_item_t ev;
        evt_fire <= rst_n && evt_ch.valid && evt_ch.ready;
        if (rst_n && evt_ch.valid && evt_ch.ready)
        begin
            ev.op    = evt_ch.op;
            ev.value = evt_ch.value;
            ev.tag   = evt_ch.tag;
            awaited_results.push_back(apply_event(ev));
        end
    end

    always @(posedge clk)
    begin : check_results
        engine_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: result with no event pending: tag %h min %h empty %b st %0d",
                             res_ch.tag_out, res_ch.min_value, res_ch.is_empty, res_ch.status);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (res_ch.tag_out !== want.tag_out || res_ch.min_value !== want.min_value ||
                    res_ch.is_empty !== want.is_empty || res_ch.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: exp tag %h min %h empty %b st %0d, got %h %h %b %0d",
                                 want.tag_out, want.min_value, want.is_empty, want.status,
                                 res_ch.tag_out, res_ch.min_value, res_ch.is_empty,
                                 res_ch.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("min_multiset_event_engine verification failed");
            $finish;
        end
    end

    task automatic push_event(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                              logic [TAG_W-1:0] tag);
        event_item_t ev;
        ev.op    = op;
        ev.value = value;
        ev.tag   = tag;
        pending_events.push_back(ev);
        total_pushed++;
    endtask

    // Holds the sender back until every event has been answered.
    task automatic wait_drained();
        while (pending_events.size() > 0 || evt_ch.valid || awaited_results.size() > 0)
            @(negedge clk);
    endtask

    // Fills the store to capacity, overflows it, then empties it in random order.
    task automatic push_fill_cycle();
        logic [VALUE_W-1:0] fill_vals[$];
        logic [VALUE_W-1:0] v;
        int idx;
        for (int i = 0; i < STORE_CAP; i++)
        begin
            if (i > 0 && $urandom_range(0, 3) == 0)
                v = fill_vals[$urandom_range(0, i - 1)];
            else
                v = $urandom;
            fill_vals.push_back(v);
            push_event(OP_INSERT, v, TAG_W'($urandom_range(0, 65535)));
        end
        push_event(OP_INSERT, 32'h0000_0000, 16'hF000);
        push_event(OP_INSERT, 32'hFFFF_FFFF, 16'hF001);
        push_event(OP_QUERY, $urandom, 16'hF002);
        while (fill_vals.size() > 0)
        begin
            idx = $urandom_range(0, fill_vals.size() - 1);
            push_event(OP_REMOVE, fill_vals[idx], TAG_W'($urandom_range(0, 65535)));
            fill_vals.delete(idx);
        end
        push_event(OP_QUERY, $urandom, 16'hF003);
    endtask

    // One stretch of random events; the weights steer the store toward full or empty.
    task automatic push_random_phase(int count, int ins_pct, int rem_pct);
        logic [VALUE_W-1:0] pool[8];
        logic [VALUE_W-1:0] extremes[4];
        logic [VALUE_W-1:0] v;
        logic [OP_W-1:0]    op;
        int mode;
        int roll;
        extremes[0] = 32'h0000_0000;
        extremes[1] = 32'hFFFF_FFFF;
        extremes[2] = 32'h8000_0000;
        extremes[3] = 32'h0000_0001;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < 8; i++)
        begin
            case (mode)
                0: pool[i] = $urandom_range(0, 15);
                1: pool[i] = 32'hFFFF_FFF0 | $urandom_range(0, 15);
                default: pool[i] = $urandom;
            endcase
        end
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = OP_SPARE;
            else if (roll < 3 + ins_pct)
                op = OP_INSERT;
            else if (roll < 3 + ins_pct + rem_pct)
                op = OP_REMOVE;
            else
                op = OP_QUERY;
            roll = $urandom_range(0, 99);
            if (roll < 60)
                v = pool[$urandom_range(0, 7)];
            else if (roll < 70)
                v = extremes[$urandom_range(0, 3)];
            else
                v = $urandom;
            push_event(op, v, TAG_W'($urandom_range(0, 65535)));
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int kind;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Empty store, absent removes, duplicates, extremes and the spare op code.
        push_event(OP_QUERY,  32'h1234_5678, 16'h0000);
        push_event(OP_REMOVE, 32'h0000_0005, 16'h0001);
        push_event(OP_SPARE,  32'hDEAD_BEEF, 16'h0002);
        push_event(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        push_event(OP_INSERT, 32'h0000_0000, 16'h0003);
        push_event(OP_INSERT, 32'h0000_0000, 16'h0004);
        push_event(OP_QUERY,  32'hFFFF_FFFF, 16'h0005);
        push_event(OP_REMOVE, 32'h0000_0000, 16'h0006);
        push_event(OP_QUERY,  32'h0000_0000, 16'h0007);
        push_event(OP_REMOVE, 32'h0000_0000, 16'h0008);
        push_event(OP_QUERY,  32'h0000_0000, 16'h0009);
        push_event(OP_REMOVE, 32'h7FFF_FFFF, 16'h000A);
        push_event(OP_INSERT, 32'h8000_0000, 16'h5555);
        push_event(OP_SPARE,  32'h0000_0000, 16'hAAAA);
        push_event(OP_REMOVE, 32'hFFFF_FFFF, 16'h000B);
        push_event(OP_REMOVE, 32'h8000_0000, 16'h000C);
        push_event(OP_QUERY,  32'hFFFF_FFFF, 16'h000D);
        push_event(OP_REMOVE, 32'h0000_0000, 16'h000E);
        wait_drained();

        push_fill_cycle();
        wait_drained();

        phase = 0;
        while (total_pushed < TARGET_ITEMS)
        begin
            kind = $urandom_range(0, 2);
            if (phase == 3)
            begin
                // Full-rate stretch on both sides.
                wait_drained();
                no_stall = 1'b1;
                push_random_phase(120, 40, 40);
                wait_drained();
                no_stall = 1'b0;
            end
            else if (kind == 0)
                push_random_phase($urandom_range(60, 140), 75, 12);
            else if (kind == 1)
                push_random_phase($urandom_range(60, 140), 15, 70);
            else
                push_random_phase($urandom_range(60, 140), 38, 38);
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("min_multiset_event_engine verification clean");
        else
            $display("min_multiset_event_engine verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mme_pkg.sv
hw/rtl/mme_if.sv
hw/rtl/mme_front.sv
hw/rtl/mme_queue.sv
hw/rtl/mme_back.sv
hw/rtl/min_multiset_event_engine.sv
hw/rtl/mme_checker.sv
test/tb_min_multiset_event_engine.sv
